[sv/mdgr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the matrix downmixer with gain ramp.
// Used by every module of the block; depends on nothing.
package mdgr_pkg;

	localparam int NUM_CH_MAX   = 32;
	localparam int MAX_BLOCK    = 4096;
	localparam int CH_W         = 5;
	localparam int NIN_W        = 6;
	localparam int BLK_W        = 13;
	localparam int FRM_W        = 12;
	localparam int GAIN_W       = 20;
	localparam int SMP_W        = 16;
	localparam int ADDR_W       = 2 * CH_W;
	localparam int NUM_W        = 35;
	localparam int G_W          = 36;
	localparam int PROD_W       = SMP_W + G_W;
	localparam int ACC_W        = 56;
	localparam int FRAC_W       = 16;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] REG_OUT_CNT = 2'd0;
	localparam logic [1:0] REG_IN_CNT  = 2'd1;
	localparam logic [1:0] REG_BLK_LEN = 2'd2;

	typedef enum logic [1:0] {
		K_WRITE,
		K_SAMPLE,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [CH_W-1:0]         source_channel;
		logic [CH_W-1:0]         target_channel;
		logic [GAIN_W-1:0]       gain_value;
		logic                    ramp_enable;
		logic signed [SMP_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]         out_channel;
		logic signed [SMP_W-1:0] out_sample;
		logic                    frame_last;
	} out_item_t;

	typedef struct packed {
		kind_t                   kind;
		logic [CH_W-1:0]         src;
		logic [CH_W-1:0]         dst;
		logic [GAIN_W-1:0]       gain;
		logic                    ramp;
		logic signed [SMP_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [NIN_W-1:0] nin;
		logic [CH_W-1:0]  nout;
		logic [BLK_W-1:0] len;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [BLK_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic init_done;
		logic div_wait;
	} back_sts_t;

endpackage
`default_nettype wire

[sv/mdgr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts items, decodes the operation and drops unused codes.
// Depends on mdgr_pkg.
module mdgr_front import mdgr_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           enable,
	input  wire           in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          cmd_valid,
	output cmd_t          cmd,
	input  wire           cmd_ready
);

	logic  v_s1;
	cmd_t  cmd_s1;
	logic  keep;
	kind_t kind;

	assign in_ready  = enable && (!v_s1 || cmd_ready);
	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

	always_comb begin
		keep = 1'b1;
		kind = K_SAMPLE;
		unique case (in_item.operation)
			OP_WRITE:  kind = K_WRITE;
			OP_SAMPLE: kind = K_SAMPLE;
			OP_CLEAR:  kind = K_CLEAR;
			default:   keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= keep;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.kind   <= kind;
			cmd_s1.src    <= in_item.source_channel;
			cmd_s1.dst    <= in_item.target_channel;
			cmd_s1.gain   <= in_item.gain_value;
			cmd_s1.ramp   <= in_item.ramp_enable;
			cmd_s1.sample <= in_item.sample_value;
		end
	end

endmodule
`default_nettype wire

[sv/mdgr_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue between front and back end.
// Depends on mdgr_pkg.
module mdgr_fifo import mdgr_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push_valid,
	output logic      push_ready,
	input  wire cmd_t push_data,
	output logic      pop_valid,
	input  wire       pop_ready,
	output cmd_t      pop_data
);

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

[sv/mdgr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Radix-2 restoring divider for the gain ramp, quotient truncated toward zero.
// One quotient bit per cycle. Depends on mdgr_pkg.
module mdgr_div import mdgr_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int MAG_W = NUM_W - 1;
	localparam int CNT_W = $clog2(MAG_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [BLK_W-1:0] rem_q;
	logic [BLK_W-1:0] den_q;
	logic [MAG_W-1:0] quo_q;
	logic [BLK_W:0]   rem_sh;
	logic [BLK_W:0]   rem_nx;
	logic             ge;
	logic signed [NUM_W-1:0] num_abs;

	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_nx  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	assign num_abs = req.num[NUM_W-1] ? -req.num : req.num;

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= num_abs[MAG_W-1:0];
			rem_q <= '0;
			neg_q <= req.num[NUM_W-1];
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], ge};
			rem_q <= rem_nx[BLK_W-1:0];
		end
	end

endmodule
`default_nettype wire

[sv/mdgr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back end: gain banks, ramp, multiply-accumulate, rounding and result output.
// Depends on mdgr_pkg; drives the divider through div_req_t / div_rsp_t.
module mdgr_back import mdgr_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  wire cfg_t      cfg,
	input  wire            cmd_valid,
	output logic           cmd_ready,
	input  wire cmd_t      cmd,
	output logic           out_valid,
	input  wire            out_ready,
	output out_item_t      out_item,
	output div_req_t       div_req,
	input  wire div_rsp_t  div_rsp,
	output back_sts_t      sts
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_CALC   = 4'd3;
	localparam logic [3:0] S_DSTART = 4'd4;
	localparam logic [3:0] S_DWAIT  = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_ACC    = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;
	localparam logic [3:0] S_SWEEP  = 4'd9;

	localparam int DEPTH = NUM_CH_MAX * NUM_CH_MAX;

	logic [3:0]              state_q;
	logic                    sel_q;
	logic                    hist_q;
	logic [NUM_CH_MAX-1:0]   flags_q;
	logic [NUM_CH_MAX-1:0]   fresh_q;
	logic [CH_W-1:0]         ch_q;
	logic [CH_W-1:0]         c_q;
	logic [FRM_W-1:0]        fc_q;
	logic                    ramp_q;
	logic [ADDR_W-1:0]       swp_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [GAIN_W-1:0] bank0 [DEPTH];
	logic [GAIN_W-1:0] bank1 [DEPTH];
	logic [GAIN_W-1:0] rd0_s;
	logic [GAIN_W-1:0] rd1_s;

	logic signed [SMP_W-1:0]  smp_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [G_W-1:0]    g_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q [NUM_CH_MAX];

	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wa;
	logic [GAIN_W-1:0]        wd;
	logic                     we0;
	logic                     we1;
	logic [GAIN_W-1:0]        cur;
	logic [GAIN_W-1:0]        prev;
	logic signed [GAIN_W:0]   diff;
	logic [BLK_W-1:0]         fcp1;
	logic signed [NUM_W-1:0]  num_c;
	logic signed [G_W-1:0]    g_ramp;
	logic signed [ACC_W-1:0]  acc_cur;
	logic signed [ACC_W-1:0]  acc_sum;
	logic                     last_c;
	logic                     frame_end;
	logic                     block_end;
	logic                     out_load;
	logic                     write_ok;

	function automatic logic [SMP_W-1:0] finish_sample(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic [ACC_W-FRAC_W-1:0] whole;
		logic [FRAC_W-1:0]       frac;
		logic                    up;
		logic [SMP_W-1:0]        res;
		hi    = {{(ACC_W-31){1'b0}}, 15'h7fff, 16'h0000};
		lo    = {{(ACC_W-32){1'b1}}, 16'h8000, 16'h0000};
		whole = a[ACC_W-1:FRAC_W];
		frac  = a[FRAC_W-1:0];
		up    = (frac > 16'h8000) || ((frac == 16'h8000) && whole[0]);
		res   = whole[SMP_W-1:0] + {{(SMP_W-1){1'b0}}, up};
		if (a > hi) res = 16'h7fff;
		if (a < lo) res = 16'h8000;
		return res;
	endfunction

	assign rd_addr = {ch_q, c_q};
	assign cur     = sel_q ? rd1_s : rd0_s;
	assign prev    = sel_q ? rd0_s : rd1_s;
	assign diff    = $signed({1'b0, cur}) - $signed({1'b0, prev});
	assign fcp1    = {1'b0, fc_q} + BLK_W'(1);
	assign num_c   = diff * $signed({1'b0, fcp1});
	assign g_ramp  = $signed({{(G_W-GAIN_W){1'b0}}, prev}) + G_W'(div_rsp.quot);
	assign acc_cur = fresh_q[c_q] ? acc_q[c_q] : '0;
	assign acc_sum = acc_cur + ACC_W'(prod_q);

	assign last_c    = ({1'b0, c_q} + NIN_W'(1)) >= {1'b0, cfg.nout};
	assign frame_end = ({1'b0, ch_q} + NIN_W'(1)) >= cfg.nin;
	assign block_end = fcp1 >= cfg.len;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign write_ok  = (fc_q == '0) && (ch_q == '0);

	assign cmd_ready     = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign div_req.start = (state_q == S_DSTART);
	assign div_req.num   = num_q;
	assign div_req.den   = cfg.len;
	assign sts.init_done = (state_q != S_INIT);
	assign sts.div_wait  = (state_q == S_DWAIT);

	// bank write port: reset sweep, block-end clear, gain writes
	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa  = swp_q;
		wd  = '0;
		unique case (state_q)
			S_INIT: begin
				we0 = 1'b1;
				we1 = 1'b1;
			end
			S_SWEEP: begin
				we0 = !sel_q;
				we1 = sel_q;
			end
			S_IDLE: begin
				if (cmd_valid && cmd.kind == K_WRITE && write_ok) begin
					wa  = {cmd.src, cmd.dst};
					wd  = cmd.gain;
					we0 = !sel_q;
					we1 = sel_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we0) bank0[wa] <= wd;
		rd0_s <= bank0[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we1) bank1[wa] <= wd;
		rd1_s <= bank1[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sel_q       <= 1'b0;
			hist_q      <= 1'b0;
			flags_q     <= '0;
			fresh_q     <= '0;
			ch_q        <= '0;
			c_q         <= '0;
			fc_q        <= '0;
			ramp_q      <= 1'b0;
			swp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					swp_q <= swp_q + ADDR_W'(1);
					if (swp_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							K_WRITE: begin
								if (write_ok) flags_q[cmd.src] <= cmd.ramp;
							end
							K_CLEAR: hist_q <= 1'b0;
							K_SAMPLE: begin
								c_q     <= '0;
								ramp_q  <= hist_q && flags_q[ch_q];
								state_q <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD:     state_q <= S_CALC;
				S_CALC:   state_q <= ramp_q ? S_DSTART : S_MUL;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_rsp.done) state_q <= S_MUL;
				end
				S_MUL:    state_q <= S_ACC;
				S_ACC: begin
					fresh_q[c_q] <= 1'b1;
					if (!last_c) begin
						c_q     <= c_q + CH_W'(1);
						state_q <= S_RD;
					end else if (!frame_end) begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_IDLE;
					end else begin
						c_q     <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						if (last_c) begin
							fresh_q <= '0;
							ch_q    <= '0;
							if (!block_end) begin
								fc_q    <= fc_q + FRM_W'(1);
								state_q <= S_IDLE;
							end else begin
								// current gains become history; clear the new current bank
								fc_q    <= '0;
								sel_q   <= !sel_q;
								flags_q <= '0;
								hist_q  <= 1'b1;
								swp_q   <= '0;
								state_q <= S_SWEEP;
							end
						end else begin
							c_q <= c_q + CH_W'(1);
						end
					end
				end
				S_SWEEP: begin
					swp_q <= swp_q + ADDR_W'(1);
					if (swp_q == '1) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.kind == K_SAMPLE) smp_q <= cmd.sample;
		if (state_q == S_CALC) begin
			num_q <= num_c;
			g_q   <= $signed({{(G_W-GAIN_W){1'b0}}, cur});
		end
		if (state_q == S_DWAIT && div_rsp.done) g_q <= g_ramp;
		if (state_q == S_MUL) prod_q <= smp_q * g_q;
		if (state_q == S_ACC) acc_q[c_q] <= acc_sum;
		if (out_load) begin
			out_q.out_channel <= c_q;
			out_q.out_sample  <= finish_sample(acc_cur);
			out_q.frame_last  <= last_c;
		end
	end

endmodule
`default_nettype wire

[sv/matrix_downmix_with_gain_ramp_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Matrix downmixer with per-block linear gain ramp: config registers and wiring.
// Sample: per output channel read, calc, multiply, accumulate; ramping adds a divide step.
// A frame end emits one result per output channel; writes and clears are taken while idle.
// Throughput is set by the shared multiply-accumulate sequencer and the divider.
// A sweep zeroes both gain banks after reset, and the new current bank at every block end;
// no item is taken during the reset pass, and queued items wait during the block-end pass.
module matrix_downmix_with_gain_ramp_top import mdgr_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire in_item_t      in_item,
	output logic               out_valid,
	input  wire                out_ready,
	output out_item_t          out_item,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CH_W-1:0]  out_cnt_q;
	logic [NIN_W-1:0] in_cnt_q;
	logic [BLK_W-1:0] blk_len_q;
	cfg_t             cfg;
	logic [NIN_W-1:0] nin_m1;

	logic      cmd_valid_f;
	logic      cmd_ready_f;
	cmd_t      cmd_f;
	logic      cmd_valid_b;
	logic      cmd_ready_b;
	cmd_t      cmd_b;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	back_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= CH_W'(2);
			in_cnt_q  <= NIN_W'(3);
			blk_len_q <= BLK_W'(1024);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_OUT_CNT: out_cnt_q <= pwdata[CH_W-1:0];
				REG_IN_CNT:  in_cnt_q  <= pwdata[NIN_W-1:0];
				REG_BLK_LEN: blk_len_q <= pwdata[BLK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OUT_CNT: prdata = PDATA_W'(out_cnt_q);
			REG_IN_CNT:  prdata = PDATA_W'(in_cnt_q);
			REG_BLK_LEN: prdata = PDATA_W'(blk_len_q);
			default:     prdata = '0;
		endcase
	end

	// clamp the counts to the ranges the datapath handles
	always_comb begin
		cfg.nin = in_cnt_q;
		if (in_cnt_q < NIN_W'(2)) cfg.nin = NIN_W'(2);
		if (in_cnt_q > NIN_W'(NUM_CH_MAX)) cfg.nin = NIN_W'(NUM_CH_MAX);
		nin_m1 = cfg.nin - NIN_W'(1);
		cfg.nout = out_cnt_q;
		if (out_cnt_q == '0) cfg.nout = CH_W'(1);
		if ({1'b0, out_cnt_q} > nin_m1) cfg.nout = nin_m1[CH_W-1:0];
		cfg.len = blk_len_q;
		if (blk_len_q == '0) cfg.len = BLK_W'(1);
		if (blk_len_q > BLK_W'(MAX_BLOCK)) cfg.len = BLK_W'(MAX_BLOCK);
	end

	mdgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (sts.init_done),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (cmd_valid_f),
		.cmd       (cmd_f),
		.cmd_ready (cmd_ready_f)
	);

	mdgr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid_f),
		.push_ready (cmd_ready_f),
		.push_data  (cmd_f),
		.pop_valid  (cmd_valid_b),
		.pop_ready  (cmd_ready_b),
		.pop_data   (cmd_b)
	);

	mdgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mdgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid_b),
		.cmd_ready (cmd_ready_b),
		.cmd       (cmd_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	a_no_out_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.init_done |-> !out_valid)
		else $error("result presented during gain bank init");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> sts.div_wait)
		else $error("divider finished while back end not waiting");

	a_div_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_req.start)
		else $error("divider restarted on consecutive cycles");
`endif

endmodule
`default_nettype wire

[tb/matrix_downmix_with_gain_ramp_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the matrix downmixer with gain ramp: driver, monitor and predictor.
// Depends on mdgr_pkg and matrix_downmix_with_gain_ramp_top only.
module matrix_downmix_with_gain_ramp_top_test;
	import mdgr_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam longint SAT_HI = 64'sd32767 * 65536;
	localparam longint SAT_LO = -64'sd32768 * 65536;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	matrix_downmix_with_gain_ramp_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// mixer state mirror
	logic [GAIN_W-1:0] cur_gain [NUM_CH_MAX*NUM_CH_MAX];
	logic [GAIN_W-1:0] prev_gain [NUM_CH_MAX*NUM_CH_MAX];
	bit ramp_on [NUM_CH_MAX];
	bit hist_ok;
	int frame_pos, chan_pos;
	longint mix_acc [NUM_CH_MAX];
	int reg_out_cnt, reg_in_cnt, reg_blk_len;

	in_item_t pending_items[$];
	out_item_t expected_mix[$];
	bit in_taken;
	int idle_pct, stall_pct;
	int mismatches;
	int gen_frame;
	int total_items;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("FAIL matrix_downmix_with_gain_ramp_top");
		$finish;
	end

	function automatic int n_in();
		return (reg_in_cnt < 2) ? 2 : (reg_in_cnt > NUM_CH_MAX) ? NUM_CH_MAX : reg_in_cnt;
	endfunction

	function automatic int n_out();
		int ni;
		ni = n_in();
		return (reg_out_cnt < 1) ? 1 : (reg_out_cnt > ni - 1) ? ni - 1 : reg_out_cnt;
	endfunction

	function automatic int n_blk();
		return (reg_blk_len < 1) ? 1 : (reg_blk_len > MAX_BLOCK) ? MAX_BLOCK : reg_blk_len;
	endfunction

	// saturate, then round half to even
	function automatic logic [SMP_W-1:0] to_pcm(longint a);
		longint u, whole, frac;
		if (a > SAT_HI) a = SAT_HI;
		if (a < SAT_LO) a = SAT_LO;
		u = a - SAT_LO;
		whole = u >>> 16;
		frac = u & 64'hFFFF;
		if (frac > 64'h8000 || (frac == 64'h8000 && whole[0])) whole++;
		return SMP_W'(whole - 32768);
	endfunction

	task automatic mix_item(input in_item_t it);
		int ni, no, len, c;
		longint g, cp, pv;
		out_item_t r;
		ni = n_in();
		no = n_out();
		len = n_blk();
		case (it.operation)
			OP_WRITE: begin
				if (frame_pos == 0 && chan_pos == 0) begin
					cur_gain[it.source_channel * NUM_CH_MAX + it.target_channel] = it.gain_value;
					ramp_on[it.source_channel] = it.ramp_enable;
				end
			end
			OP_CLEAR: hist_ok = 0;
			OP_SAMPLE: begin
				for (c = 0; c < no; c++) begin
					cp = cur_gain[chan_pos * NUM_CH_MAX + c];
					g = cp;
					if (hist_ok && ramp_on[chan_pos]) begin
						pv = prev_gain[chan_pos * NUM_CH_MAX + c];
						g = pv + ((cp - pv) * longint'(frame_pos + 1)) / longint'(len);
					end
					mix_acc[c] += longint'(it.sample_value) * g;
				end
				if (chan_pos + 1 < ni) begin
					chan_pos++;
				end else begin
					for (c = 0; c < no; c++) begin
						r.out_channel = CH_W'(c);
						r.out_sample = to_pcm(mix_acc[c]);
						r.frame_last = (c == no - 1);
						expected_mix.push_back(r);
					end
					foreach (mix_acc[i]) mix_acc[i] = 0;
					chan_pos = 0;
					if (frame_pos + 1 < len) begin
						frame_pos++;
					end else begin
						frame_pos = 0;
						foreach (cur_gain[i]) begin
							prev_gain[i] = cur_gain[i];
							cur_gain[i] = '0;
						end
						foreach (ramp_on[i]) ramp_on[i] = 0;
						hist_ok = 1;
					end
				end
			end
			default: ;
		endcase
	endtask

	// driver
	always @(negedge clk) begin
		bit busy;
		busy = in_valid && !in_taken;
		in_taken = 0;
		if (!busy) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && in_valid && in_ready) begin
			mix_item(in_item);
			in_taken = 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result ch=%0d smp=%0d last=%0b",
						out_item.out_channel, out_item.out_sample, out_item.frame_last);
			end else begin
				want = expected_mix.pop_front();
				if (out_item.out_channel !== want.out_channel ||
						out_item.out_sample !== want.out_sample ||
						out_item.frame_last !== want.frame_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ch=%0d smp=%0d last=%0b got ch=%0d smp=%0d last=%0b",
							want.out_channel, want.out_sample, want.frame_last,
							out_item.out_channel, out_item.out_sample, out_item.frame_last);
				end
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input int val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= PDATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_OUT_CNT: reg_out_cnt = val & 32'h1F;
			REG_IN_CNT:  reg_in_cnt = val & 32'h3F;
			default:     reg_blk_len = val & 32'h1FFF;
		endcase
	endtask

	task automatic add_item(input logic [1:0] op, input int src, input int dst,
			input logic [GAIN_W-1:0] gain, input bit ramp, input logic [SMP_W-1:0] smp);
		in_item_t it;
		it.operation = op;
		it.source_channel = CH_W'(src);
		it.target_channel = CH_W'(dst);
		it.gain_value = gain;
		it.ramp_enable = ramp;
		it.sample_value = smp;
		pending_items.push_back(it);
		total_items++;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return GAIN_W'(20'h10000);
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// frames of samples; gain writes at each block start, with some noise items
	task automatic add_frames(input int frames);
		int f, k, s, nw, ni, no, len;
		ni = n_in();
		no = n_out();
		len = n_blk();
		for (f = 0; f < frames; f++) begin
			if (gen_frame == 0) begin
				nw = $urandom_range(6);
				for (k = 0; k < nw; k++) begin
					if ($urandom_range(9) == 0)
						add_item(OP_WRITE, $urandom_range(31), $urandom_range(31),
							pick_gain(), $urandom_range(1), SMP_W'($urandom));
					else
						add_item(OP_WRITE, $urandom_range(ni - 1), $urandom_range(no - 1),
							pick_gain(), $urandom_range(3) != 0, SMP_W'($urandom));
				end
				if ($urandom_range(7) == 0)
					add_item(OP_CLEAR, $urandom_range(31), $urandom_range(31),
						GAIN_W'($urandom), $urandom_range(1), SMP_W'($urandom));
			end
			for (s = 0; s < ni; s++) begin
				if ($urandom_range(29) == 0)
					add_item($urandom_range(1) ? OP_RESERVED : OP_WRITE, $urandom_range(31),
						$urandom_range(31), GAIN_W'($urandom), $urandom_range(1),
						SMP_W'($urandom));
				else if ($urandom_range(39) == 0)
					add_item(OP_CLEAR, 0, 0, '0, 0, '0);
				add_item(OP_SAMPLE, $urandom_range(31), $urandom_range(31),
					GAIN_W'($urandom), $urandom_range(1), pick_sample());
			end
			gen_frame = (gen_frame + 1 >= len) ? 0 : gen_frame + 1;
		end
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_mix.size() > 0)
			@(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 69; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 69; end
			default: begin idle_pct = 27; stall_pct = 27; end
		endcase
	endtask

	task automatic run_phase(input int oc, input int ic, input int bl, input int frames,
			input int mode);
		reg_write(REG_OUT_CNT, oc);
		reg_write(REG_IN_CNT, ic);
		reg_write(REG_BLK_LEN, bl);
		set_idle(mode);
		add_frames(frames);
		drain();
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_taken = 0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		total_items = 0;
		gen_frame = 0;
		reg_out_cnt = 2;
		reg_in_cnt = 3;
		reg_blk_len = 1024;
		hist_ok = 0;
		frame_pos = 0;
		chan_pos = 0;
		foreach (cur_gain[i]) begin
			cur_gain[i] = '0;
			prev_gain[i] = '0;
		end
		foreach (ramp_on[i]) ramp_on[i] = 0;
		foreach (mix_acc[i]) mix_acc[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (1100) @(posedge clk);

		// directed: extremes, every operation, writes outside counts and inside a frame
		reg_write(REG_BLK_LEN, 2);
		add_item(OP_WRITE, 0, 0, 20'hFFFFF, 1, '0);
		add_item(OP_WRITE, 1, 1, 20'h10000, 0, '0);
		add_item(OP_WRITE, 2, 0, 20'h00000, 1, '0);
		add_item(OP_WRITE, 31, 31, 20'hFFFFF, 1, 16'hFFFF);
		add_item(OP_RESERVED, 31, 31, 20'hFFFFF, 1, 16'hFFFF);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h7FFF);
		add_item(OP_WRITE, 0, 1, 20'h12345, 1, '0);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h8000);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h0001);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h8000);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h8000);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h8000);
		add_item(OP_WRITE, 0, 0, 20'h00000, 1, '0);
		add_item(OP_WRITE, 1, 0, 20'h08000, 1, '0);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h7FFF);
		add_item(OP_CLEAR, 0, 0, '0, 0, '0);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h0001);
		add_item(OP_SAMPLE, 0, 0, '0, 0, 16'h7FFF);
		drain();

		run_phase(31, 32, 1, 1, 1);
		run_phase(0, 0, 0, 3, 2);
		run_phase(31, 40, 1, 1, 3);
		run_phase(3, 5, 4096, 3, 0);
		run_phase(1, 2, 8191, 2, 1);
		run_phase(2, 3, 1, 4, 2);
		ph = 0;
		while (total_items < 300) begin
			run_phase($urandom_range(1, 6), $urandom_range(2, 8), $urandom_range(1, 4),
				$urandom_range(2, 8), ph);
			ph++;
		end

		if (mismatches == 0)
			$display("PASS matrix_downmix_with_gain_ramp_top");
		else
			$display("FAIL matrix_downmix_with_gain_ramp_top");
		$finish;
	end

endmodule
